// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/skti_pkg.sv -----
// Package for the sorted key table insert unit: sizes, codes and payload types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package skti_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int CHILD_W  = 16;
  localparam int RANK_W   = 4;
  localparam int STAT_W   = 2;
  localparam int PLACE_W  = 4;
  localparam int SCOUNT_W = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0]  CFG_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_CMP_SIGNED = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CAP_RESET      = 5'd16;
  localparam logic [CHILD_W-1:0]    NO_CHILD       = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_RANK = 2'd2
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [KEY_W-1:0]          key;
    logic signed [CHILD_W-1:0] child;
    logic [RANK_W-1:0]         rank;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [PLACE_W-1:0]        placed_at;
    logic [KEY_W-1:0]          read_key;
    logic signed [CHILD_W-1:0] read_child;
    logic [SCOUNT_W-1:0]       stored_count;
  } rsp_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic                shift_en;
    logic                cmp_signed;
    logic [KEY_BITS-1:0] new_key;
    logic [CHILD_W-1:0]  new_child;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/skti_cell.sv -----
// One compare-and-shift cell of the sorted chain: holds the pair of one rank.
// Depends on skti_pkg.
`default_nettype none

module skti_cell (
  input  wire                          clk,
  input  skti_pkg::cell_ctl_t          ctl,
  input  wire                          occ,
  input  wire                          left_lt,
  input  wire [skti_pkg::KEY_BITS-1:0] left_key,
  input  wire [skti_pkg::CHILD_W-1:0]  left_child,
  output logic                         lt,
  output logic [skti_pkg::KEY_BITS-1:0] key,
  output logic [skti_pkg::CHILD_W-1:0]  child
);
  import skti_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CHILD_W-1:0]  child_r, child_nxt;
  logic [KEY_BITS-1:0] flip;

  // Flip the top bit so a signed order becomes an unsigned one.
  assign flip = {ctl.cmp_signed, {(KEY_BITS-1){1'b0}}};
  assign lt   = occ && ((key_r ^ flip) < (ctl.new_key ^ flip));

  always_comb begin
    key_nxt   = key_r;
    child_nxt = child_r;
    if (ctl.shift_en && !lt) begin
      if (left_lt) begin
        key_nxt   = ctl.new_key;
        child_nxt = ctl.new_child;
      end else begin
        key_nxt   = left_key;
        child_nxt = left_child;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    child_r <= child_nxt;
  end

  assign key   = key_r;
  assign child = child_r;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_key_table_insert_unit.sv -----
// Sorted key table insert unit: one B-tree style node of up to CAPACITY (key, child)
// pairs held in ascending key order in a chain of compare-and-shift cells. Each
// cell compares its key with the incoming one; cells at or after the insertion
// point take their left neighbour's pair and the first of them takes the new pair;
// a key equal to stored keys goes ahead of them. Every request (insert, read by
// rank, clear) yields one result, registered and shown in the cycle after
// acceptance. The unit takes one request per cycle; it stalls only while its
// output register holds a result that the downstream side is stalling. No
// clearing pass after reset: a request may be sent in the first cycle after reset
// is released. Configuration writes are taken in any cycle (cfg_ready is always
// high) and are meant for idle periods.
// Depends on skti_pkg and skti_cell.
`default_nettype none

module sorted_key_table_insert_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  // request channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  skti_pkg::req_t                 in_req,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output skti_pkg::rsp_t                 out_rsp,
  // configuration write channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [skti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [skti_pkg::CFG_DATA_W-1:0] cfg_data
);
  import skti_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cap_r;
  logic                  cmp_signed_r;

  // Fill level of the chain; cells below it hold valid pairs.
  logic [CNT_W-1:0] count_r, count_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r, rsp_nxt;

  logic      in_acc;
  logic      full;
  cell_ctl_t ctl;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt;
  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [CHILD_W-1:0]  cell_child [CAPACITY];

  logic [POS_W-1:0]    pos;
  logic                rd_hit;
  logic [KEY_BITS-1:0] rd_key;
  logic [CHILD_W-1:0]  rd_child;

  // Hold the request while a finished result waits downstream.
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Refuse inserts at the programmed capacity, saturated at the chain length.
  assign full = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= CAPACITY);

  // ---------------------------------------------------------------------------
  // Chain of cells
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl.shift_en   = in_acc && (in_req.kind == KIND_INSERT) && !full;
    ctl.cmp_signed = cmp_signed_r;
    ctl.new_key    = KEY_BITS'(in_req.key);
    ctl.new_child  = in_req.child;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = (count_r > CNT_W'(g));
    if (g == 0) begin : g_head
      skti_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[g]),
        .left_lt    (1'b1),
        .left_key   (ctl.new_key),
        .left_child (ctl.new_child),
        .lt         (lt[g]),
        .key        (cell_key[g]),
        .child      (cell_child[g])
      );
    end else begin : g_body
      skti_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ[g]),
        .left_lt    (lt[g-1]),
        .left_key   (cell_key[g-1]),
        .left_child (cell_child[g-1]),
        .lt         (lt[g]),
        .key        (cell_key[g]),
        .child      (cell_child[g])
      );
    end
  end

  // Insertion point: first cell whose key is not below the new one.
  always_comb begin
    pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // Read by rank: select the cell, only if it holds a valid pair.
  always_comb begin
    rd_hit   = 1'b0;
    rd_key   = '0;
    rd_child = NO_CHILD;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((32'(in_req.rank) == i) && occ[i]) begin
        rd_hit   = 1'b1;
        rd_key   = cell_key[i];
        rd_child = cell_child[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result and fill level
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt          = count_r;
    rsp_nxt.status     = ST_OK;
    rsp_nxt.placed_at  = '0;
    rsp_nxt.read_key   = '0;
    rsp_nxt.read_child = NO_CHILD;
    case (in_req.kind)
      KIND_INSERT: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          count_nxt         = count_r + CNT_W'(1);
          rsp_nxt.placed_at = PLACE_W'(pos);
        end
      end
      KIND_READ: begin
        if (rd_hit) begin
          rsp_nxt.read_key   = KEY_W'(rd_key);
          rsp_nxt.read_child = rd_child;
        end else begin
          rsp_nxt.status = ST_RANK;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unused code: leave the node as it is
      end
    endcase
    rsp_nxt.stored_count = SCOUNT_W'(count_nxt);
  end

  // Load a fresh result on accept; drop the old one once it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      cmp_signed_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAPACITY:   cap_r        <= cfg_data;
        CFG_CMP_SIGNED: cmp_signed_r <= cfg_data[0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ----- rtl/core/skti_checker.sv -----
// Port-level checker for the sorted key table insert unit, bound to the top level.
// Depends on skti_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module skti_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input skti_pkg::rsp_t                 out_rsp
);
  import skti_pkg::*;

  // An empty output stage never holds back a request.
  `ASSERT_IMPL(a_no_idle_stall, !out_valid, !in_stall)
  // A refused insert reports no placement.
  `ASSERT_IMPL(a_full_no_place, out_valid && (out_rsp.status == ST_FULL),
               out_rsp.placed_at == '0)
  // A read past the count returns the empty pair.
  `ASSERT_IMPL(a_rank_empty, out_valid && (out_rsp.status == ST_RANK),
               (out_rsp.read_key == '0) && (out_rsp.read_child == NO_CHILD))
  // Placement lies inside the node after the insert.
  `ASSERT_IMPL(a_place_inside, out_valid && (out_rsp.placed_at != '0),
               32'(out_rsp.placed_at) < 32'(out_rsp.stored_count))
  // An accepted request always shows a result in the next cycle.
  `ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)

endmodule

bind sorted_key_table_insert_unit skti_checker u_skti_checker (.*);

`default_nettype wire
